>>> design/glu_pkg.sv
// Package for the GCD/LCM unit: request and result structs, queue entry type, constants.
// No dependencies.
`timescale 1ns / 1ps
package glu_pkg;

  localparam int unsigned OpW = 64;
  localparam int unsigned AnsW = 63;
  localparam int unsigned QueueDepthDefault = 2;

  typedef enum logic {
    REQ_GCD = 1'b0,
    REQ_LCM = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic             req_type;
    logic [OpW-1:0]   first_operand;
    logic [OpW-1:0]   second_operand;
  } in_item_t;

  typedef struct packed {
    logic [AnsW-1:0] answer;
    logic            status;
  } out_item_t;

  // Classified job handed from the front part to the back part.
  typedef struct packed {
    logic             is_lcm;
    logic             early;      // result known without iteration
    logic             early_ovf;
    logic [AnsW-1:0]  ma;
    logic [AnsW-1:0]  mb;
  } job_t;

endpackage

>>> design/glu_front.sv
// Front part of the GCD/LCM unit: takes requests, forms magnitudes, classifies
// special cases and pushes jobs into a small queue. Depends on glu_pkg.
`timescale 1ns / 1ps
module glu_front #(
  parameter int unsigned Depth = glu_pkg::QueueDepthDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  glu_pkg::in_item_t in_item,
  output logic              job_valid,
  output glu_pkg::job_t     job,
  input  logic              job_pop
);
  import glu_pkg::*;

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t              mem_r [Depth];
  logic [IdxW-1:0]   wptr_r, rptr_r;
  logic [IdxW:0]     cnt_r;
  logic [OpW-1:0]    a, b, ma, mb;
  logic              amin, bmin, push;
  job_t              nj;

  assign busy = (cnt_r == (IdxW+1)'(Depth));
  assign push = start && !busy;

  always_comb begin
    a = in_item.first_operand;
    b = in_item.second_operand;
    amin = (a == {1'b1, {(OpW-1){1'b0}}});
    bmin = (b == {1'b1, {(OpW-1){1'b0}}});
    ma = a[OpW-1] ? (~a + OpW'(1)) : a;
    mb = b[OpW-1] ? (~b + OpW'(1)) : b;
    nj.is_lcm = (in_item.req_type == REQ_LCM);
    nj.early_ovf = amin || bmin;
    nj.early = amin || bmin || (nj.is_lcm && (ma == '0 || mb == '0));
    nj.ma = ma[AnsW-1:0];
    nj.mb = mb[AnsW-1:0];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= nj;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= (wptr_r == IdxW'(Depth-1)) ? '0 : wptr_r + 1'b1;
      if (job_pop) rptr_r <= (rptr_r == IdxW'(Depth-1)) ? '0 : rptr_r + 1'b1;
      cnt_r <= cnt_r + (IdxW+1)'(push) - (IdxW+1)'(job_pop);
    end
  end

  assign job_valid = (cnt_r != '0);
  assign job = mem_r[rptr_r];

endmodule

>>> design/glu_back.sv
// Back part of the GCD/LCM unit: Euclid by a bit-serial remainder unit, then
// the LCM quotient, product and range check. Depends on glu_pkg.
`timescale 1ns / 1ps
module glu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  glu_pkg::job_t      job,
  output logic               job_pop,
  output logic               out_strobe,
  output glu_pkg::out_item_t out_item
);
  import glu_pkg::*;

  localparam int unsigned CntW = $clog2(AnsW + 1);
  localparam int unsigned MulW = 32;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_GCD  = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_MULA = 7'b0001000,
    S_MULB = 7'b0010000,
    S_CHK  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [AnsW-1:0]     x_r, y_r, ma_r, mb_r;
  logic [AnsW-1:0]     rem_r, quo_r, dvd_r, dvs_r;
  logic [CntW-1:0]     bit_r;
  logic                is_lcm_r, div_gcd_r, ovf_r;
  logic [AnsW-1:0]     ans_r;
  logic [2*AnsW-1:0]   prod_r;
  logic [AnsW:0]       trial;
  logic [AnsW-1:0]     rem_sh;
  logic [MulW-1:0]     qlo;
  logic [MulW-1:0]     qhi;

  // One restoring-division step per cycle.
  assign rem_sh = {rem_r[AnsW-2:0], dvd_r[AnsW-1]};
  assign trial  = {rem_r, dvd_r[AnsW-1]} - {1'b0, dvs_r};
  assign qlo = {1'b0, quo_r[MulW-2:0]};
  assign qhi = quo_r[AnsW-1:MulW-1];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (job_valid) state_nxt = job.early ? S_OUT : S_GCD;
      S_GCD:  state_nxt = (y_r == '0) ? (is_lcm_r ? S_DIV : S_OUT) : S_DIV;
      S_DIV:  if (bit_r == '0) state_nxt = div_gcd_r ? S_GCD : S_MULA;
      S_MULA: state_nxt = S_MULB;
      S_MULB: state_nxt = S_CHK;
      S_CHK:  state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        x_r <= job.ma; y_r <= job.mb; ma_r <= job.ma; mb_r <= job.mb;
        is_lcm_r <= job.is_lcm; ovf_r <= job.early_ovf; ans_r <= '0;
      end
      S_GCD: begin
        if (y_r == '0) begin
          if (!is_lcm_r) ans_r <= x_r;
          dvd_r <= ma_r; dvs_r <= x_r; div_gcd_r <= 1'b0;
        end else begin
          dvd_r <= x_r; dvs_r <= y_r; div_gcd_r <= 1'b1;
        end
        rem_r <= '0; quo_r <= '0; bit_r <= CntW'(AnsW - 1);
      end
      S_DIV: begin
        if (!trial[AnsW]) rem_r <= trial[AnsW-1:0];
        else rem_r <= rem_sh;
        quo_r <= {quo_r[AnsW-2:0], !trial[AnsW]};
        dvd_r <= {dvd_r[AnsW-2:0], 1'b0};
        bit_r <= bit_r - 1'b1;
        if (bit_r == '0 && div_gcd_r) begin
          x_r <= y_r;
          y_r <= !trial[AnsW] ? trial[AnsW-1:0] : rem_sh;
        end
      end
      S_MULA: prod_r <= (2*AnsW)'(qlo * mb_r[MulW-1:0])
                      + ((2*AnsW)'(qlo * mb_r[AnsW-1:MulW]) << MulW);
      S_MULB: prod_r <= prod_r
                      + ((2*AnsW)'(qhi * mb_r[MulW-1:0]) << (MulW-1))
                      + ((2*AnsW)'(qhi * {1'b0, mb_r[AnsW-1:MulW]})
                         << (2*MulW-1));
      S_CHK: begin
        if (prod_r[2*AnsW-1:AnsW] != '0) ovf_r <= 1'b1;
        else ans_r <= prod_r[AnsW-1:0];
      end
      default: ;
    endcase
  end

  assign job_pop    = (state_r == S_IDLE) && job_valid;
  assign out_strobe = (state_r == S_OUT);
  assign out_item.answer = ovf_r ? '0 : ans_r;
  assign out_item.status = ovf_r;

endmodule

>>> design/gcd_lcm_unit.sv
// GCD/LCM unit, top level: links the request front part, job queue and back part.
// Depends on glu_pkg, glu_front and glu_back.
// Usage: raise start with in_item; the request is taken on a clock edge where
// busy is low. Each request yields exactly one result, shown for one cycle on
// out_item with out_strobe high; the receiver cannot stall it.
// Requests are classified on entry: a most negative operand gives overflow, and
// an LCM with a zero operand gives zero; either result skips Euclid, and the
// back part goes from idle straight to its output state. Other requests run
// Euclid in the back part, where every remainder takes a setup state (S_GCD)
// and a division by the one-bit-per-cycle divider (S_DIV). Up to about 90
// Euclid steps are needed for 63-bit magnitudes. An LCM adds one more
// division, the multiply states S_MULA and S_MULB and a range check (S_CHK).
// The divider sets the rate; the back part takes one job at a time.
// The queue holds Depth classified requests, so the front keeps accepting
// while the back works; busy rises only when the queue is full.
// Reset clears the queue pointers and the back part's state machine; any
// request in flight is dropped.
`timescale 1ns / 1ps
module gcd_lcm_unit #(
  parameter int unsigned Depth = glu_pkg::QueueDepthDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  glu_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output glu_pkg::out_item_t out_item
);
  import glu_pkg::*;

  job_t job;
  logic job_valid, job_pop;

  glu_front #(.Depth(Depth)) u_front (
    .clk, .rst_n, .start, .busy, .in_item,
    .job_valid, .job, .job_pop
  );

  glu_back u_back (
    .clk, .rst_n, .job_valid, .job, .job_pop, .out_strobe, .out_item
  );

endmodule

>>> design/glu_checker.sv
// Port-level checker for the GCD/LCM unit, bound to the top level.
// Depends on glu_pkg and gcd_lcm_unit.
`timescale 1ns / 1ps
module glu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input glu_pkg::in_item_t  in_item,
  input logic               out_strobe,
  input glu_pkg::out_item_t out_item
);
  import glu_pkg::*;

  // Overflow always reports a zero answer.
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.status |-> out_item.answer == '0)
    else $error("overflow result with nonzero answer");

  // Results are single-cycle strobes.
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held");

  // No result directly after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result right after reset");

  // The queue is empty after reset, so the unit is ready for a request.
  a_busy_reset: assert property (@(posedge clk)
    !rst_n |=> !busy)
    else $error("busy after reset");

endmodule

bind gcd_lcm_unit glu_checker u_glu_checker (
  .clk, .rst_n, .start, .busy, .in_item, .out_strobe, .out_item
);

>>> dv/tb_top.sv
// Self-checking testbench for gcd_lcm_unit: a table of directed requests, then random ones.
// Results are checked against the table or an in-bench predictor. Depends on glu_pkg and the unit.
`timescale 1ns / 1ps
module tb_top;
  import glu_pkg::*;

  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] FIB_92  = 64'd7540113804746346429;
  localparam logic [63:0] FIB_91  = 64'd4660046610375530309;
  localparam int unsigned NUM_RANDOM  = 680;
  localparam int unsigned CALM_TAIL   = 80;    // last requests go out back to back
  localparam int unsigned STALL_LIMIT = 100000;
  localparam int unsigned DRAIN_WAIT  = 300;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_item_t   in_item = '0;
  logic       out_strobe;
  out_item_t  out_item;

  // Results that the unit still owes us, oldest first.
  out_item_t  owed_results[$];
  int unsigned mismatch_count = 0;
  int unsigned checked_count = 0;
  int unsigned overflow_seen = 0;
  int unsigned idle_cycles = 0;

  // One row of the directed table. Where known is set, the row carries its
  // own expected answer; otherwise the predictor supplies it.
  typedef struct packed {
    req_kind_t   kind;
    logic [63:0] a;
    logic [63:0] b;
    logic        known;
    logic [62:0] answer;
    logic        status;
  } gcd_row_t;

  gcd_row_t gcd_table [22] = '{
    // A most negative operand flags overflow for both kinds of request.
    '{REQ_GCD, S64_MIN, 64'd0, 1'b1, 63'd0, 1'b1},
    '{REQ_LCM, 64'd3, S64_MIN, 1'b1, 63'd0, 1'b1},
    '{REQ_GCD, S64_MIN, S64_MIN, 1'b1, 63'd0, 1'b1},
    '{REQ_LCM, S64_MIN, S64_MAX, 1'b1, 63'd0, 1'b1},
    // Zero operands.
    '{REQ_GCD, 64'd0, 64'd0, 1'b1, 63'd0, 1'b0},
    '{REQ_GCD, 64'd0, -64'sd7, 1'b1, 63'd7, 1'b0},
    '{REQ_LCM, 64'd0, 64'd5, 1'b1, 63'd0, 1'b0},
    '{REQ_LCM, -64'sd9, 64'd0, 1'b1, 63'd0, 1'b0},
    '{REQ_LCM, 64'd0, 64'd0, 1'b1, 63'd0, 1'b0},
    // Extremes of the representable range.
    '{REQ_GCD, S64_MAX, S64_MAX, 1'b1, S64_MAX[62:0], 1'b0},
    '{REQ_GCD, -64'sd1, S64_MAX, 1'b1, 63'd1, 1'b0},
    '{REQ_LCM, S64_MAX, 64'd1, 1'b1, S64_MAX[62:0], 1'b0},
    '{REQ_LCM, -64'sd1, S64_MAX, 1'b1, S64_MAX[62:0], 1'b0},
    '{REQ_LCM, S64_MAX, 64'd2, 1'b1, 63'd0, 1'b1},
    '{REQ_LCM, 64'h4000_0000_0000_0000, 64'd2, 1'b1, 63'h4000_0000_0000_0000, 1'b0},
    '{REQ_LCM, 64'h4000_0000_0000_0000, 64'd3, 1'b1, 63'd0, 1'b1},
    // Consecutive Fibonacci numbers give Euclid its longest run.
    '{REQ_GCD, FIB_92, -FIB_91, 1'b1, 63'd1, 1'b0},
    '{REQ_LCM, FIB_92, FIB_91, 1'b1, 63'd0, 1'b1},
    // Mixed signs and ordinary values, left to the predictor.
    '{REQ_GCD, -64'sd12, 64'd18, 1'b0, 63'd0, 1'b0},
    '{REQ_LCM, -64'sd4, -64'sd6, 1'b0, 63'd0, 1'b0},
    '{REQ_GCD, 64'd123456789012, 64'd987654321098, 1'b0, 63'd0, 1'b0},
    '{REQ_LCM, -64'sd1000000007, 64'd998244353, 1'b0, 63'd0, 1'b0}
  };

  gcd_lcm_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Computes what the unit must answer for one request: Euclid on the
  // magnitudes, then the LCM with its range check against 2^63-1.
  function automatic out_item_t predict_gcd_lcm(in_item_t req);
    logic [63:0] mag_a;
    logic [63:0] mag_b;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] rem;
    logic [63:0] quot;
    out_item_t   res;
    res = '0;
    if (req.first_operand == S64_MIN || req.second_operand == S64_MIN) begin
      res.status = 1'b1;
      return res;
    end
    mag_a = req.first_operand[63] ? -req.first_operand : req.first_operand;
    mag_b = req.second_operand[63] ? -req.second_operand : req.second_operand;
    if (req.req_type == REQ_LCM && (mag_a == 0 || mag_b == 0)) return res;
    x = mag_a;
    y = mag_b;
    while (y != 0) begin
      rem = x % y;
      x = y;
      y = rem;
    end
    if (req.req_type == REQ_GCD) begin
      res.answer = x[62:0];
    end else begin
      quot = mag_a / x;
      if (quot > S64_MAX / mag_b) res.status = 1'b1;
      else res.answer = 63'(quot * mag_b);
    end
    return res;
  endfunction

  // Holds the request on the inputs until the unit takes it. Busy is sampled
  // at the falling edge, where it cannot race the driving edge.
  task automatic issue_request(in_item_t req, out_item_t want);
    logic taken;
    start <= 1'b1;
    in_item <= req;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    owed_results.push_back(want);
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 7)) @(posedge clk);
  endtask

  // A random operand. Most are short so Euclid stays quick; some use the full
  // width, and a few land on the boundary values.
  function automatic logic [63:0] random_operand();
    logic [63:0] v;
    int unsigned len;
    case ($urandom_range(0, 19))
      0: return 64'd0;
      1: return S64_MIN;
      2: return S64_MAX;
      3: return -64'sd1;
      default: begin
        v = {$urandom(), $urandom()};
        len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 24) : $urandom_range(25, 64);
        if (len < 64) v = v & ((64'd1 << len) - 64'd1);
        if ($urandom_range(0, 1) == 1) v = -v;
        return v;
      end
    endcase
  endfunction

  function automatic in_item_t random_request();
    in_item_t    req;
    logic [63:0] shared;
    req.req_type = $urandom_range(0, 1) ? REQ_LCM : REQ_GCD;
    req.first_operand = random_operand();
    req.second_operand = random_operand();
    // Give about a third of the pairs a common factor so the GCD is not 1.
    if ($urandom_range(0, 2) == 0) begin
      shared = 64'($urandom_range(2, 5000));
      req.first_operand = (req.first_operand & 64'hFFFF_FFFF) * shared;
      req.second_operand = (req.second_operand & 64'h0FFF_FFFF) * shared;
    end
    return req;
  endfunction

  // Checks each result against the oldest owed one, and watches for a hang.
  always @(negedge clk) begin
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (owed_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: result with nothing owed: answer=%0d status=%0b",
                   out_item.answer, out_item.status);
      end else begin
        want = owed_results.pop_front();
        checked_count++;
        if (out_item.status) overflow_seen++;
        if (out_item.answer !== want.answer || out_item.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: result %0d: expected answer=%0d status=%0b, got answer=%0d status=%0b",
                     checked_count, want.answer, want.status, out_item.answer, out_item.status);
        end
      end
    end
    if (out_strobe || (start && !busy)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= STALL_LIMIT) begin
      $display("ERROR: no progress for %0d cycles, %0d results still owed",
               STALL_LIMIT, owed_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    in_item_t  req;
    out_item_t want;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    foreach (gcd_table[i]) begin
      req.req_type = gcd_table[i].kind;
      req.first_operand = gcd_table[i].a;
      req.second_operand = gcd_table[i].b;
      if (gcd_table[i].known) begin
        want.answer = gcd_table[i].answer;
        want.status = gcd_table[i].status;
      end else begin
        want = predict_gcd_lcm(req);
      end
      issue_request(req, want);
      if ($urandom_range(0, 2) == 0) idle_burst();
    end

    // Let the unit empty out completely before the random part.
    start <= 1'b0;
    do @(negedge clk); while (owed_results.size() != 0);
    @(posedge clk);

    // Random requests, idling in bursts except in the last stretch.
    for (int unsigned n = 0; n < NUM_RANDOM; n++) begin
      req = random_request();
      issue_request(req, predict_gcd_lcm(req));
      if (n < NUM_RANDOM - CALM_TAIL && $urandom_range(0, 3) == 0) idle_burst();
    end
    start <= 1'b0;

    do @(negedge clk); while (owed_results.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);

    $display("Checked %0d results over %0d directed and %0d random requests;",
             checked_count, $size(gcd_table), NUM_RANDOM);
    $display("%0d of them flagged overflow, %0d mismatches.", overflow_seen, mismatch_count);
    if (mismatch_count == 0 && owed_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> gcd_lcm_unit.f
design/glu_pkg.sv
design/glu_front.sv
design/glu_back.sv
design/gcd_lcm_unit.sv
design/glu_checker.sv
dv/tb_top.sv
